// ===== rtl/tbn_pkg.sv =====
// Shared types, character codes and queue sizes of the text engine byte normalizer.
package tbn_pkg;

    // Input item queue between the front and the back.
    localparam int unsigned IQ_DEPTH = 4;
    localparam int unsigned IQ_PTR_W = $clog2(IQ_DEPTH);
    localparam logic [IQ_PTR_W:0] IQ_CNT_FULL = (IQ_PTR_W + 1)'(IQ_DEPTH);

    // Result queue in front of the output ports.
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam logic [OQ_PTR_W:0] OQ_CNT_FULL = (OQ_PTR_W + 1)'(OQ_DEPTH);

    // Byte window: four held bytes plus the one just taken in.
    localparam int unsigned WIN_DEPTH = 5;
    localparam int unsigned WIN_IDX_W = $clog2(WIN_DEPTH);

    // Item opcodes.
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Raw byte values that drive classification.
    localparam logic [7:0] BYTE_BSLASH = 8'h5C;
    localparam logic [7:0] BYTE_BOM_FE = 8'hFE;
    localparam logic [7:0] BYTE_BOM_FF = 8'hFF;
    localparam logic [4:0] SUR_TOP     = 5'b11011;

    // Output characters.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_Z      = 8'h5A;

    typedef struct packed {
        logic hi_bit;
        logic bslash;
        logic lt;
        logic gt;
        logic lparen;
        logic rparen;
        logic bom_fe;
        logic bom_ff;
        logic sur_hi;
    } byte_class_t;

    typedef struct packed {
        logic [7:0]  data;
        byte_class_t cls;
    } win_entry_t;

    typedef struct packed {
        logic       op;
        win_entry_t ent;
    } item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       done;
    } res_t;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_SKIP   = 3'b010,
        MODE_UTF    = 3'b100
    } mode_t;

endpackage

// ===== rtl/tbn_front.sv =====
// Front part: accepts input beats, classifies the byte and queues the item for the back.
module tbn_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                op,
    input  logic [7:0]          data_byte,
    output logic                item_valid,
    output tbn_pkg::item_t      item,
    input  logic                item_pop
);

    tbn_pkg::item_t                 q_mem [tbn_pkg::IQ_DEPTH];
    logic [tbn_pkg::IQ_PTR_W-1:0]   wr_ptr_reg;
    logic [tbn_pkg::IQ_PTR_W-1:0]   wr_ptr_next;
    logic [tbn_pkg::IQ_PTR_W-1:0]   rd_ptr_reg;
    logic [tbn_pkg::IQ_PTR_W-1:0]   rd_ptr_next;
    logic [tbn_pkg::IQ_PTR_W:0]     cnt_reg;
    logic [tbn_pkg::IQ_PTR_W:0]     cnt_next;
    logic                           accept;
    logic                           take;
    tbn_pkg::item_t                 new_item;

    // All the byte tests the back needs are made once here and travel with the byte.
    always_comb
    begin
        new_item            = '0;
        new_item.op         = op;
        new_item.ent.data   = data_byte;
        new_item.ent.cls.hi_bit = data_byte[7];
        new_item.ent.cls.bslash = (data_byte == tbn_pkg::BYTE_BSLASH);
        new_item.ent.cls.lt     = (data_byte == tbn_pkg::CH_LT);
        new_item.ent.cls.gt     = (data_byte == tbn_pkg::CH_GT);
        new_item.ent.cls.lparen = (data_byte == tbn_pkg::CH_LPAREN);
        new_item.ent.cls.rparen = (data_byte == tbn_pkg::CH_RPAREN);
        new_item.ent.cls.bom_fe = (data_byte == tbn_pkg::BYTE_BOM_FE);
        new_item.ent.cls.bom_ff = (data_byte == tbn_pkg::BYTE_BOM_FF);
        new_item.ent.cls.sur_hi = (data_byte[7:3] == tbn_pkg::SUR_TOP);
    end

    assign full       = (cnt_reg == tbn_pkg::IQ_CNT_FULL);
    assign item_valid = (cnt_reg != '0);
    assign item       = q_mem[rd_ptr_reg];
    assign accept     = push & ~full;
    assign take       = item_pop & item_valid;

    always_comb
    begin
        wr_ptr_next = accept ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + {{tbn_pkg::IQ_PTR_W{1'b0}}, accept}
                              - {{tbn_pkg::IQ_PTR_W{1'b0}}, take};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/tbn_out_queue.sv =====
// Result queue that holds finished characters until the output side pops them.
module tbn_out_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            res_push,
    input  tbn_pkg::res_t   res,
    output logic            oq_full,
    output logic            empty,
    input  logic            pop,
    output logic [7:0]      out_char,
    output logic            run_last,
    output logic            text_done
);

    tbn_pkg::res_t                  q_mem [tbn_pkg::OQ_DEPTH];
    logic [tbn_pkg::OQ_PTR_W-1:0]   wr_ptr_reg;
    logic [tbn_pkg::OQ_PTR_W-1:0]   wr_ptr_next;
    logic [tbn_pkg::OQ_PTR_W-1:0]   rd_ptr_reg;
    logic [tbn_pkg::OQ_PTR_W-1:0]   rd_ptr_next;
    logic [tbn_pkg::OQ_PTR_W:0]     cnt_reg;
    logic [tbn_pkg::OQ_PTR_W:0]     cnt_next;
    logic                           wr_en;
    logic                           rd_en;
    tbn_pkg::res_t                  head;

    assign oq_full   = (cnt_reg == tbn_pkg::OQ_CNT_FULL);
    assign empty     = (cnt_reg == '0);
    assign head      = q_mem[rd_ptr_reg];
    assign out_char  = head.ch;
    assign run_last  = head.last;
    assign text_done = head.done;
    assign wr_en     = res_push & ~oq_full;
    assign rd_en     = pop & ~empty;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + {{tbn_pkg::OQ_PTR_W{1'b0}}, wr_en}
                              - {{tbn_pkg::OQ_PTR_W{1'b0}}, rd_en};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_mem[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/tbn_back.sv =====
// Back part: byte window, rewrite decisions and the character sequencer.
module tbn_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  tbn_pkg::item_t  item,
    output logic            item_pop,
    input  logic            oq_full,
    output logic            res_push,
    output tbn_pkg::res_t   res
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PREFIX = 5'b00010,
        ST_RUN    = 5'b00100,
        ST_SUFFIX = 5'b01000,
        ST_FLUSH  = 5'b10000
    } state_t;

    typedef struct packed {
        logic               progress;
        logic [2:0]         k;
        logic [2:0]         cons;
        logic [3:0][7:0]    chars;
        tbn_pkg::mode_t     mode_nx;
        logic               be_nx;
    } dec_t;

    state_t                         state_reg, state_next;
    tbn_pkg::win_entry_t            win_reg [tbn_pkg::WIN_DEPTH];
    tbn_pkg::win_entry_t            win_next [tbn_pkg::WIN_DEPTH];
    tbn_pkg::win_entry_t            win_sh [tbn_pkg::WIN_DEPTH];
    logic [tbn_pkg::WIN_IDX_W-1:0]  win_cnt_reg, win_cnt_next;
    tbn_pkg::mode_t                 mode_reg, mode_next;
    logic                           be_reg, be_next;
    logic                           fin_reg, fin_next;
    logic                           started_reg, started_next;
    logic [2:0]                     idx_reg, idx_next;
    logic                           hold_valid_reg, hold_valid_next;
    logic [7:0]                     hold_ch_reg, hold_ch_next;
    logic                           hold_done_reg, hold_done_next;

    dec_t                           dec;
    logic [2:0]                     cons_eff;
    logic                           go;
    logic                           emit;
    logic [7:0]                     emit_ch;
    logic                           emit_done;
    logic                           finish;
    logic                           load;
    logic                           apply;

    function automatic logic [7:0] prefix_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = tbn_pkg::CH_SLASH;
            3'd1:    c = tbn_pkg::CH_ZERO;
            3'd2:    c = tbn_pkg::CH_SPACE;
            3'd3:    c = tbn_pkg::CH_LT;
            default: c = tbn_pkg::CH_SPACE;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] suffix_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = tbn_pkg::CH_SPACE;
            3'd1:    c = tbn_pkg::CH_GT;
            default: c = tbn_pkg::CH_NUL;
        endcase
        return c;
    endfunction

    // Decision for the head of the window.
    always_comb
    begin
        logic lo_bs;
        logic hi_sur;
        logic same_br;
        logic bom;
        lo_bs   = be_reg ? win_reg[1].cls.bslash : win_reg[0].cls.bslash;
        hi_sur  = be_reg ? win_reg[0].cls.sur_hi : win_reg[1].cls.sur_hi;
        same_br = (win_reg[0].cls.lt & win_reg[1].cls.lt)
                | (win_reg[0].cls.gt & win_reg[1].cls.gt);
        bom     = (win_reg[1].cls.bom_fe & win_reg[2].cls.bom_ff)
                | (win_reg[1].cls.bom_ff & win_reg[2].cls.bom_fe);

        dec.progress = 1'b0;
        dec.k        = 3'd0;
        dec.cons     = 3'd0;
        dec.chars    = {4{tbn_pkg::CH_DOT}};
        dec.mode_nx  = mode_reg;
        dec.be_nx    = be_reg;

        if (win_cnt_reg != '0)
        begin
            unique case (mode_reg)
                tbn_pkg::MODE_SKIP:
                begin
                    dec.progress = 1'b1;
                    dec.cons     = 3'd1;
                    dec.mode_nx  = tbn_pkg::MODE_NORMAL;
                end
                tbn_pkg::MODE_UTF:
                begin
                    priority if (win_reg[0].cls.rparen)
                    begin
                        dec.progress = 1'b1;
                        dec.k        = 3'd1;
                        dec.cons     = 3'd1;
                        dec.chars[0] = tbn_pkg::CH_RPAREN;
                        dec.mode_nx  = tbn_pkg::MODE_NORMAL;
                    end
                    else if (win_cnt_reg < 3'd4)
                    begin
                        dec.progress = fin_reg;
                        dec.k        = 3'd2;
                        dec.cons     = 3'd2;
                    end
                    else if (lo_bs)
                    begin
                        dec.progress = 1'b1;
                        dec.k        = 3'd3;
                        dec.cons     = 3'd3;
                    end
                    else if (hi_sur && win_cnt_reg >= 3'd5)
                    begin
                        dec.progress = 1'b1;
                        dec.k        = 3'd4;
                        dec.cons     = 3'd4;
                    end
                    else if (hi_sur)
                    begin
                        // Surrogate without its fifth byte: plain unit at end of text.
                        dec.progress = fin_reg;
                        dec.k        = 3'd2;
                        dec.cons     = 3'd2;
                    end
                    else
                    begin
                        dec.progress = 1'b1;
                        dec.k        = 3'd2;
                        dec.cons     = 3'd2;
                    end
                end
                tbn_pkg::MODE_NORMAL:
                begin
                    priority if (win_reg[0].cls.hi_bit || win_reg[0].cls.bslash)
                    begin
                        dec.progress = 1'b1;
                        dec.k        = 3'd1;
                        dec.cons     = 3'd1;
                        dec.chars[0] = win_reg[0].cls.hi_bit ? tbn_pkg::CH_W : tbn_pkg::CH_Z;
                        dec.mode_nx  = tbn_pkg::MODE_SKIP;
                    end
                    else if (win_reg[0].cls.lt || win_reg[0].cls.gt)
                    begin
                        if (win_cnt_reg >= 3'd2 && same_br)
                        begin
                            dec.progress = 1'b1;
                            dec.k        = 3'd2;
                            dec.cons     = 3'd2;
                            dec.chars[0] = win_reg[0].data;
                            dec.chars[1] = tbn_pkg::CH_SPACE;
                        end
                        else
                        begin
                            dec.progress = (win_cnt_reg >= 3'd2) | fin_reg;
                            dec.k        = 3'd1;
                            dec.cons     = 3'd1;
                            dec.chars[0] = tbn_pkg::CH_J;
                        end
                    end
                    else if (win_reg[0].cls.lparen)
                    begin
                        dec.chars[0] = tbn_pkg::CH_LPAREN;
                        if (win_cnt_reg >= 3'd3 && bom)
                        begin
                            dec.progress = 1'b1;
                            dec.k        = 3'd3;
                            dec.cons     = 3'd3;
                            dec.chars[1] = tbn_pkg::CH_T;
                            dec.chars[2] = tbn_pkg::CH_M;
                            dec.mode_nx  = tbn_pkg::MODE_UTF;
                            dec.be_nx    = win_reg[1].cls.bom_fe;
                        end
                        else
                        begin
                            dec.progress = (win_cnt_reg >= 3'd3) | fin_reg;
                            dec.k        = 3'd1;
                            dec.cons     = 3'd1;
                        end
                    end
                    else
                    begin
                        dec.progress = 1'b1;
                        dec.k        = 3'd1;
                        dec.cons     = 3'd1;
                        dec.chars[0] = win_reg[0].data;
                    end
                end
                default:
                begin
                    dec.progress = 1'b0;
                end
            endcase
        end
    end

    // A short unit at end of text can ask for more bytes than are held.
    assign cons_eff = (dec.cons > win_cnt_reg) ? win_cnt_reg : dec.cons;

    always_comb
    begin
        for (int i = 0; i < tbn_pkg::WIN_DEPTH; i++)
        begin
            logic [tbn_pkg::WIN_IDX_W:0] src;
            src = (tbn_pkg::WIN_IDX_W + 1)'(i) + {1'b0, cons_eff};
            if (src < (tbn_pkg::WIN_IDX_W + 1)'(tbn_pkg::WIN_DEPTH))
            begin
                win_sh[i] = win_reg[src[tbn_pkg::WIN_IDX_W-1:0]];
            end
            else
            begin
                win_sh[i] = win_reg[i];
            end
        end
    end

    assign go = ~oq_full;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        win_next        = win_reg;
        win_cnt_next    = win_cnt_reg;
        mode_next       = mode_reg;
        be_next         = be_reg;
        fin_next        = fin_reg;
        started_next    = started_reg;
        idx_next        = idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_ch_next    = hold_ch_reg;
        hold_done_next  = hold_done_reg;
        emit            = 1'b0;
        emit_ch         = tbn_pkg::CH_NUL;
        emit_done       = 1'b0;
        finish          = 1'b0;
        load            = 1'b0;
        apply           = 1'b0;
        item_pop        = 1'b0;
        res_push        = 1'b0;
        res             = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                load = go & item_valid;
            end
            ST_PREFIX:
            begin
                if (go)
                begin
                    emit    = 1'b1;
                    emit_ch = prefix_char(idx_reg);
                    if (idx_reg == 3'd4)
                    begin
                        idx_next   = 3'd0;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            ST_RUN:
            begin
                if (go)
                begin
                    if (dec.progress)
                    begin
                        if (dec.k == 3'd0)
                        begin
                            apply = 1'b1;
                        end
                        else
                        begin
                            emit    = 1'b1;
                            emit_ch = dec.chars[idx_reg[1:0]];
                            if (idx_reg == dec.k - 3'd1)
                            begin
                                apply    = 1'b1;
                                idx_next = 3'd0;
                            end
                            else
                            begin
                                idx_next = idx_reg + 3'd1;
                            end
                        end
                    end
                    else if (fin_reg)
                    begin
                        state_next = ST_SUFFIX;
                        idx_next   = 3'd0;
                    end
                    else
                    begin
                        finish     = 1'b1;
                        state_next = ST_IDLE;
                        load       = item_valid;
                    end
                end
            end
            ST_SUFFIX:
            begin
                if (go)
                begin
                    emit      = 1'b1;
                    emit_ch   = suffix_char(idx_reg);
                    emit_done = (idx_reg == 3'd2);
                    if (idx_reg == 3'd2)
                    begin
                        idx_next   = 3'd0;
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (go)
                begin
                    finish       = 1'b1;
                    state_next   = ST_IDLE;
                    started_next = 1'b0;
                    mode_next    = tbn_pkg::MODE_NORMAL;
                    be_next      = 1'b1;
                    win_cnt_next = '0;
                    fin_next     = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (apply)
        begin
            win_next     = win_sh;
            win_cnt_next = win_cnt_reg - cons_eff;
            mode_next    = dec.mode_nx;
            be_next      = dec.be_nx;
        end

        if (load)
        begin
            item_pop     = 1'b1;
            fin_next     = (item.op == tbn_pkg::OP_END);
            started_next = 1'b1;
            idx_next     = 3'd0;
            state_next   = started_reg ? ST_RUN : ST_PREFIX;
            if (item.op == tbn_pkg::OP_DATA)
            begin
                win_next[win_cnt_reg] = item.ent;
                win_cnt_next          = win_cnt_reg + 1'b1;
            end
        end

        // The newest character waits in the hold register until it is known
        // whether another one of the same item follows it.
        if (emit)
        begin
            res_push        = hold_valid_reg;
            res.ch          = hold_ch_reg;
            res.last        = 1'b0;
            res.done        = hold_done_reg;
            hold_valid_next = 1'b1;
            hold_ch_next    = emit_ch;
            hold_done_next  = emit_done;
        end
        else if (finish)
        begin
            res_push        = hold_valid_reg;
            res.ch          = hold_ch_reg;
            res.last        = 1'b1;
            res.done        = hold_done_reg;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg     <= win_next;
        hold_ch_reg <= hold_ch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            win_cnt_reg    <= '0;
            mode_reg       <= tbn_pkg::MODE_NORMAL;
            be_reg         <= 1'b1;
            fin_reg        <= 1'b0;
            started_reg    <= 1'b0;
            idx_reg        <= 3'd0;
            hold_valid_reg <= 1'b0;
            hold_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            win_cnt_reg    <= win_cnt_next;
            mode_reg       <= mode_next;
            be_reg         <= be_next;
            fin_reg        <= fin_next;
            started_reg    <= started_next;
            idx_reg        <= idx_next;
            hold_valid_reg <= hold_valid_next;
            hold_done_reg  <= hold_done_next;
        end
    end

endmodule

// ===== rtl/text_engine_byte_normalizer_top.sv =====
// Top level of the text engine byte normalizer: front, back and result queue.
//
// The block rewrites a byte stream, closed by an end-of-text beat (op = 1), into a
// tokenizer-friendly character stream that opens with "/0 < " and closes with " >"
// and a zero character flagged by text_done. Input beats are taken whenever full is
// low; results leave oldest first while empty is low, and run_last marks the last
// character caused by each input beat (a beat may cause none, when its byte only
// waits in the lookahead window). The back sequencer emits each output character
// and drops each skipped byte as a step of its own; after each data beat a further
// step sees that the window needs more bytes and also takes the next beat from the
// input queue. A beat that finds the back idle is first loaded in a step of its own.
// A text adds the five prefix characters, a step to see the window empty at end of
// text, the three suffix characters and a step to close and return to idle. The
// sequencer waits whenever the result queue is full. The four-entry input queue and
// four-entry result queue let the input side run ahead and keep the sequencer busy
// while the result side stalls.
module text_engine_byte_normalizer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_char,
    output logic        run_last,
    output logic        text_done
);

    logic               item_valid;
    tbn_pkg::item_t     item;
    logic               item_pop;
    logic               oq_full;
    logic               res_push;
    tbn_pkg::res_t      res;

    // The front classifies each byte as it is taken in and queues it.
    tbn_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .data_byte  (data_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    // Holds the byte window; emits at most one char per cycle, none while oq_full.
    tbn_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .oq_full    (oq_full),
        .res_push   (res_push),
        .res        (res)
    );

    // Finished characters wait here for the output side.
    tbn_out_queue u_out_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_push   (res_push),
        .res        (res),
        .oq_full    (oq_full),
        .empty      (empty),
        .pop        (pop),
        .out_char   (out_char),
        .run_last   (run_last),
        .text_done  (text_done)
    );

endmodule

// ===== rtl/tbn_checker.sv =====
// Port-level checker for the byte normalizer and its bind to the top level.
module tbn_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  out_char,
    input  logic        run_last,
    input  logic        text_done
);

    // The closing zero is always the last character of the end-of-text beat.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && text_done) |-> run_last)
        else $error("text_done shown without run_last");

    // Only the closing character carries text_done, and it is a zero.
    a_done_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && text_done) |-> (out_char == tbn_pkg::CH_NUL))
        else $error("text_done on a nonzero character");

    // A waiting result beat stays put until it is popped.
    a_head_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(out_char) && $stable(run_last) && $stable(text_done)))
        else $error("result beat changed while waiting");

    a_head_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result beat vanished without a pop");

endmodule

bind text_engine_byte_normalizer_top tbn_checker u_tbn_checker (.*);
